### hw/rtl/mbs_pkg.sv
package mbs_pkg;

    // stream characters
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_DASH = 8'h2D;

    // fixed CR LF dash dash delimiter prefix
    localparam int unsigned PREFIX_LEN = 4;

    // item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DATA = 1'b1;

    // configuration register map (word index)
    localparam logic REG_TOKEN_LENGTH = 1'b0;

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPW         = $clog2(QUEUE_DEPTH);

    // field widths
    localparam int unsigned TOKEN_LEN_W = 7;
    localparam int unsigned SEG_W       = 16;

    typedef enum logic [1:0] {
        PH_SCAN,
        PH_DASH,
        PH_SKIP
    } phase_t;

    typedef struct packed {
        logic                   opcode;
        logic [6:0]             token_index;
        logic [7:0]             byte_value;
        logic                   end_of_data;
    } item_t;

    typedef struct packed {
        logic [SEG_W-1:0]       segment_length;
        logic                   segment_end;
        logic                   closing_marker;
        logic [SEG_W-1:0]       segment_number;
    } result_t;

    // classified word handed from front to back
    typedef struct packed {
        logic                   is_load;
        logic                   idx_ok;
        logic [6:0]             token_index;
        logic [7:0]             byte_value;
        logic                   eod;
        logic                   is_cr;
        logic                   is_lf;
        logic                   is_dash;
    } queue_word_t;

    // byte of the fixed delimiter prefix
    function automatic logic [7:0] prefix_byte(input logic [1:0] pos);
        logic [7:0] b;
        begin
            case (pos)
                2'd0:    b = CHAR_CR;
                2'd1:    b = CHAR_LF;
                default: b = CHAR_DASH;
            endcase
            return b;
        end
    endfunction

endpackage

### hw/rtl/mbs_front.sv
module mbs_front #(
    parameter int MAX_TOKEN = 70
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  mbs_pkg::item_t      item,
    output logic                q_valid,
    output mbs_pkg::queue_word_t q_word,
    input  logic                q_pop
);
    import mbs_pkg::*;

    queue_word_t          ents [QUEUE_DEPTH];
    logic [QPW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QPW:0]         count_reg, count_next;
    queue_word_t          cls;
    logic                 push;

    // classify the incoming word
    always_comb
    begin
        cls.is_load     = (item.opcode == OP_LOAD);
        cls.idx_ok      = (32'(item.token_index) < 32'(MAX_TOKEN));
        cls.token_index = item.token_index;
        cls.byte_value  = item.byte_value;
        cls.eod         = item.end_of_data;
        cls.is_cr       = (item.byte_value == CHAR_CR);
        cls.is_lf       = (item.byte_value == CHAR_LF);
        cls.is_dash     = (item.byte_value == CHAR_DASH);
    end

    assign item_ready = (count_reg != (QPW+1)'(QUEUE_DEPTH));
    assign push       = item_valid && item_ready;
    assign q_valid    = (count_reg != '0);
    assign q_word     = ents[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ents[wr_ptr_reg] <= cls;
        end
    end

endmodule

### hw/rtl/mbs_back.sv
module mbs_back #(
    parameter int MAX_TOKEN  = 70,
    parameter int COUNT_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  mbs_pkg::queue_word_t           q_word,
    output logic                           q_pop,
    input  logic [mbs_pkg::TOKEN_LEN_W-1:0] token_length,
    output logic                           result_valid,
    input  logic                           result_ready,
    output mbs_pkg::result_t               result
);
    import mbs_pkg::*;

    localparam int AW = (MAX_TOKEN > 1) ? $clog2(MAX_TOKEN) : 1;
    localparam int MW = $clog2(MAX_TOKEN + PREFIX_LEN);
    localparam int LW = MW + 1;
    localparam int CW = COUNT_BITS;

    logic [7:0]     tok_mem [MAX_TOKEN];
    logic [7:0]     tok_rd_reg;
    logic [AW-1:0]  rd_addr;
    logic           tok_we;

    phase_t         phase_reg, phase_next;
    logic [MW-1:0]  mp_reg, mp_next;
    logic [CW-1:0]  body_reg, body_next;
    logic [SEG_W-1:0] seg_reg, seg_next;
    logic [1:0]     dc_reg, dc_next;
    logic           res_valid_reg;
    result_t        res_reg;

    logic [TOKEN_LEN_W-1:0] tl_clamp;
    logic [LW-1:0]  delim_len;
    logic [7:0]     dbyte;
    logic           match;
    logic [CW:0]    sum_mis;
    logic [CW:0]    sum_eod;
    logic           emit;
    logic [CW-1:0]  e_len;
    logic           e_end;
    logic           e_close;
    logic           fire;

    function automatic logic [CW-1:0] sat_count(input logic [CW:0] v);
        begin
            return v[CW] ? {CW{1'b1}} : v[CW-1:0];
        end
    endfunction

    function automatic logic [SEG_W-1:0] to_len(input logic [CW-1:0] v);
        begin
            return (v > CW'(17'h0FFFF)) ? {SEG_W{1'b1}} : SEG_W'(v);
        end
    endfunction

    assign fire  = q_valid && (!res_valid_reg || result_ready);
    assign q_pop = fire;

    // delimiter length from the clamped token length
    always_comb
    begin
        tl_clamp = token_length;
        if (token_length == '0)
        begin
            tl_clamp = TOKEN_LEN_W'(1);
        end
        else if (token_length > TOKEN_LEN_W'(MAX_TOKEN))
        begin
            tl_clamp = TOKEN_LEN_W'(MAX_TOKEN);
        end
        delim_len = LW'(tl_clamp) + LW'(PREFIX_LEN);
    end

    // expected byte at the current match position
    assign dbyte = (mp_reg < MW'(PREFIX_LEN)) ? prefix_byte(mp_reg[1:0]) : tok_rd_reg;
    assign match = (q_word.byte_value == dbyte);

    // body updates on a mismatch and at end of data while scanning
    assign sum_mis = (CW+1)'(body_reg) + (CW+1)'(mp_reg) + (CW+1)'(!q_word.is_cr);
    assign sum_eod = (CW+1)'(body_reg) + (CW+1)'(mp_reg) + (CW+1)'(1);

    // matcher next state
    always_comb
    begin
        phase_next = phase_reg;
        mp_next    = mp_reg;
        body_next  = body_reg;
        seg_next   = seg_reg;
        dc_next    = dc_reg;
        emit       = 1'b0;
        e_len      = body_reg;
        e_end      = 1'b0;
        e_close    = 1'b0;
        tok_we     = 1'b0;

        if (fire)
        begin
            if (q_word.is_load)
            begin
                tok_we = q_word.idx_ok;
            end
            else
            begin
                unique case (phase_reg)
                    PH_DASH:
                    begin
                        if (q_word.is_dash)
                        begin
                            if (dc_reg != 2'd0)
                            begin
                                dc_next    = 2'd2;
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                dc_next = 2'd1;
                            end
                        end
                        else
                        begin
                            dc_next    = 2'd0;
                            phase_next = PH_SKIP;
                            if (q_word.is_lf)
                            begin
                                emit       = 1'b1;
                                e_len      = body_reg;
                                e_close    = 1'b0;
                                seg_next   = seg_reg + 1'b1;
                                body_next  = '0;
                                mp_next    = '0;
                                phase_next = PH_SCAN;
                            end
                        end
                    end
                    PH_SKIP:
                    begin
                        if (q_word.is_lf)
                        begin
                            emit       = 1'b1;
                            e_len      = body_reg;
                            e_close    = (dc_reg == 2'd2);
                            seg_next   = seg_reg + 1'b1;
                            body_next  = '0;
                            mp_next    = '0;
                            dc_next    = 2'd0;
                            phase_next = PH_SCAN;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_SCAN;
                        if (match)
                        begin
                            if ((LW'(mp_reg) + LW'(1)) >= delim_len)
                            begin
                                mp_next    = '0;
                                dc_next    = 2'd0;
                                phase_next = PH_DASH;
                            end
                            else
                            begin
                                mp_next = mp_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            body_next = sat_count(sum_mis);
                            mp_next   = q_word.is_cr ? MW'(1) : '0;
                        end
                    end
                endcase

                // end of data closes the segment and clears stream state
                if (q_word.eod)
                begin
                    if (!emit)
                    begin
                        emit = 1'b1;
                        if (phase_next == PH_SCAN)
                        begin
                            e_len   = sat_count(sum_eod);
                            e_end   = 1'b1;
                            e_close = 1'b0;
                        end
                        else
                        begin
                            e_len   = body_next;
                            e_end   = 1'b0;
                            e_close = (dc_next == 2'd2);
                        end
                    end
                    phase_next = PH_SCAN;
                    mp_next    = '0;
                    body_next  = '0;
                    seg_next   = '0;
                    dc_next    = 2'd0;
                end
            end
        end
    end

    // prefetch the token byte for the next match position
    assign rd_addr = (mp_next >= MW'(PREFIX_LEN)) ? AW'(mp_next - MW'(PREFIX_LEN)) : '0;

    // token store
    always_ff @(posedge clk)
    begin
        if (tok_we)
        begin
            tok_mem[AW'(q_word.token_index)] <= q_word.byte_value;
        end
        if (tok_we && (AW'(q_word.token_index) == rd_addr))
        begin
            tok_rd_reg <= q_word.byte_value;
        end
        else
        begin
            tok_rd_reg <= tok_mem[rd_addr];
        end
    end

    // matcher state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SCAN;
            mp_reg    <= '0;
            body_reg  <= '0;
            seg_reg   <= '0;
            dc_reg    <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            mp_reg    <= mp_next;
            body_reg  <= body_next;
            seg_reg   <= seg_next;
            dc_reg    <= dc_next;
        end
    end

    // result output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fire && emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            res_reg.segment_length <= to_len(e_len);
            res_reg.segment_end    <= e_end;
            res_reg.closing_marker <= e_close;
            res_reg.segment_number <= seg_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

### hw/rtl/multipart_boundary_splitter.sv
// Multipart boundary splitter: takes one word per cycle, either a token load
// (writes one boundary token byte) or a stream byte, and reports the length of
// each segment found between CR LF "--" token delimiters, with a flag for the
// closing "--" marker and a running segment number that end of data clears.
// A word enters every cycle while the result side keeps up; the rate is set
// by the one-compare match loop, which prefetches the next expected token
// byte from the registered token store so one byte completes per cycle.
// A result is registered: an accepted word waits in the input queue, the
// matcher works on it at the queue head, and the result register then loads
// when the word leaves the queue. The token store has no reset; load every
// token byte in use before streaming data.
// token_length lives at byte address 0 of the APB port.
module multipart_boundary_splitter #(
    parameter int MAX_TOKEN  = 70,
    parameter int COUNT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  mbs_pkg::item_t     item,
    output logic               result_valid,
    input  logic               result_ready,
    output mbs_pkg::result_t   result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import mbs_pkg::*;

    logic [TOKEN_LEN_W-1:0] token_length_reg;
    logic                   q_valid;
    queue_word_t            q_word;
    logic                   q_pop;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TOKEN_LENGTH) ? 32'(token_length_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_length_reg <= TOKEN_LEN_W'(1);
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_TOKEN_LENGTH))
        begin
            token_length_reg <= pwdata[TOKEN_LEN_W-1:0];
        end
    end

    // accept and classify
    mbs_front #(
        .MAX_TOKEN (MAX_TOKEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_valid    (q_valid),
        .q_word     (q_word),
        .q_pop      (q_pop)
    );

    // delimiter matching and segment results
    mbs_back #(
        .MAX_TOKEN  (MAX_TOKEN),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_word       (q_word),
        .q_pop        (q_pop),
        .token_length (token_length_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
